@@ design/mtd_pkg.sv @@
// ----------------------------------------------------------------------------
// mtd_pkg
// Shared constants, types and fixed-point helpers for the multi-tap delay.
// ----------------------------------------------------------------------------
`default_nettype none

package mtd_pkg;

    // Block sizing
    localparam int MAX_TAPS    = 8;
    localparam int LINE_DEPTH  = 65536;
    localparam int SAMPLE_BITS = 16;

    localparam int LINE_BITS = $clog2(LINE_DEPTH);
    localparam int TAP_BITS  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int CNT_BITS  = $clog2(MAX_TAPS + 1);
    localparam int ADDR_BITS = TAP_BITS + LINE_BITS;
    localparam int MEM_DEPTH = 1 << ADDR_BITS;

    // Register field widths
    localparam int TAP_COUNT_BITS = 4;
    localparam int SPACING_BITS   = 14;
    localparam int LEVEL_BITS     = 16;
    localparam int GAIN_BITS      = 16;
    localparam logic [GAIN_BITS-1:0] GAIN_ONE = GAIN_BITS'(32768);

    // Arithmetic widths
    localparam int FRAC_BITS = 15;
    localparam int WET_BITS  = SAMPLE_BITS + $clog2(MAX_TAPS);
    localparam int PROD_BITS = GAIN_BITS + 1 + WET_BITS;
    localparam int ACC_BITS  = PROD_BITS + 1;
    localparam int DLY_BITS  = LINE_BITS + 1;
    localparam int SUM_BITS  = ((DLY_BITS > SPACING_BITS) ? DLY_BITS : SPACING_BITS) + 1;

    localparam logic signed [ACC_BITS-1:0] ROUND_HALF = ACC_BITS'(1 << (FRAC_BITS - 1));
    localparam logic signed [ACC_BITS-1:0] SAT_HI     = ACC_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [ACC_BITS-1:0] SAT_LO     = -SAT_HI - ACC_BITS'(1);

    // Configuration port
    localparam int PADDR_BITS = 5;
    localparam int PDATA_BITS = 32;
    localparam int REG_IDX_BITS = 3;

    localparam logic [REG_IDX_BITS-1:0] REG_TAP_COUNT   = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_TAP_SPACING = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_DRY_LEVEL   = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_WET_LEVEL   = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_FEEDBACK    = 3'd4;

    // Effective settings after clamping
    typedef struct packed {
        logic [CNT_BITS-1:0]     taps;
        logic [SPACING_BITS-1:0] spacing;
        logic [GAIN_BITS-1:0]    dry;
        logic [GAIN_BITS-1:0]    wet;
        logic [GAIN_BITS-1:0]    fb;
    } t_cfg;

    // Delay memory access
    typedef struct packed {
        logic                   we;
        logic [ADDR_BITS-1:0]   waddr;
        logic [SAMPLE_BITS-1:0] wdata;
        logic [ADDR_BITS-1:0]   raddr;
    } t_ram_req;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_WRITE,
        S_MIX_DRY,
        S_MIX_WET,
        S_DONE
    } t_state;

    // Round half up on a Q15 scaled value.
    function automatic logic signed [ACC_BITS-1:0] round_q15(
        input logic signed [ACC_BITS-1:0] v
    );
        logic signed [ACC_BITS-1:0] t;
        t = v + ROUND_HALF;
        return t >>> FRAC_BITS;
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
        input logic signed [ACC_BITS-1:0] v
    );
        logic signed [ACC_BITS-1:0] s;
        if (v > SAT_HI) begin
            s = SAT_HI;
        end else if (v < SAT_LO) begin
            s = SAT_LO;
        end else begin
            s = v;
        end
        return s[SAMPLE_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

@@ design/mtd_ram.sv @@
// ----------------------------------------------------------------------------
// mtd_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module mtd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ design/mtd_mul.sv @@
// ----------------------------------------------------------------------------
// mtd_mul
// Shared registered multiplier: unsigned Q1.15 gain times a signed value.
// ----------------------------------------------------------------------------
`default_nettype none

module mtd_mul (
    input  wire logic                               i_clk,
    input  wire logic                               i_en,
    input  wire logic        [mtd_pkg::GAIN_BITS-1:0] i_gain,
    input  wire logic signed [mtd_pkg::WET_BITS-1:0]  i_val,
    output logic signed      [mtd_pkg::PROD_BITS-1:0] o_prod
);

    import mtd_pkg::*;

    logic signed [PROD_BITS-1:0] r_prod;

    // The product holds while the unit is not enabled.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= $signed({1'b0, i_gain}) * i_val;
        end
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

@@ design/mtd_cfg.sv @@
// ----------------------------------------------------------------------------
// mtd_cfg
// APB register file with clamping of the effective settings.
// ----------------------------------------------------------------------------
`default_nettype none

module mtd_cfg (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [mtd_pkg::PADDR_BITS-1:0]    paddr,
    input  wire logic [mtd_pkg::PDATA_BITS-1:0]    pwdata,
    output logic      [mtd_pkg::PDATA_BITS-1:0]    prdata,
    output logic                                   pready,
    output mtd_pkg::t_cfg                          o_cfg
);

    import mtd_pkg::*;

    logic [TAP_COUNT_BITS-1:0] r_tap_count;
    logic [SPACING_BITS-1:0]   r_tap_spacing;
    logic [LEVEL_BITS-1:0]     r_dry_level;
    logic [LEVEL_BITS-1:0]     r_wet_level;
    logic [LEVEL_BITS-1:0]     r_feedback;

    logic                    wr_en;
    logic [REG_IDX_BITS-1:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_BITS-1:2];
    assign wr_en   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_count   <= TAP_COUNT_BITS'(4);
            r_tap_spacing <= SPACING_BITS'(8192);
            r_dry_level   <= LEVEL_BITS'(32768);
            r_wet_level   <= LEVEL_BITS'(32768);
            r_feedback    <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_TAP_COUNT:   r_tap_count   <= pwdata[TAP_COUNT_BITS-1:0];
                REG_TAP_SPACING: r_tap_spacing <= pwdata[SPACING_BITS-1:0];
                REG_DRY_LEVEL:   r_dry_level   <= pwdata[LEVEL_BITS-1:0];
                REG_WET_LEVEL:   r_wet_level   <= pwdata[LEVEL_BITS-1:0];
                REG_FEEDBACK:    r_feedback    <= pwdata[LEVEL_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_TAP_COUNT:   prdata = PDATA_BITS'(r_tap_count);
            REG_TAP_SPACING: prdata = PDATA_BITS'(r_tap_spacing);
            REG_DRY_LEVEL:   prdata = PDATA_BITS'(r_dry_level);
            REG_WET_LEVEL:   prdata = PDATA_BITS'(r_wet_level);
            REG_FEEDBACK:    prdata = PDATA_BITS'(r_feedback);
            default:         prdata = '0;
        endcase
    end

    // Gains above one count as one, a zero spacing counts as one sample.
    always_comb begin
        o_cfg.taps    = (int'(r_tap_count) > MAX_TAPS) ? CNT_BITS'(MAX_TAPS)
                                                        : CNT_BITS'(r_tap_count);
        o_cfg.spacing = (r_tap_spacing == '0) ? SPACING_BITS'(1) : r_tap_spacing;
        o_cfg.dry     = (r_dry_level > GAIN_ONE) ? GAIN_ONE : r_dry_level;
        o_cfg.wet     = (r_wet_level > GAIN_ONE) ? GAIN_ONE : r_wet_level;
        o_cfg.fb      = (r_feedback > GAIN_ONE) ? GAIN_ONE : r_feedback;
    end

endmodule

`default_nettype wire

@@ design/mtd_core.sv @@
// ----------------------------------------------------------------------------
// mtd_core
// Sequencer that walks the taps through the delay memory and the shared
// multiplier, then mixes dry and wet parts into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mtd_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire mtd_pkg::t_cfg                      i_cfg,
    input  wire logic                               i_s_valid,
    output logic                                    o_s_ready,
    input  wire logic [mtd_pkg::SAMPLE_BITS-1:0]    i_s_data,
    output logic                                    o_m_valid,
    input  wire logic                               i_m_ready,
    output logic      [mtd_pkg::SAMPLE_BITS-1:0]    o_m_data,
    output mtd_pkg::t_ram_req                       o_ram,
    input  wire logic [mtd_pkg::SAMPLE_BITS-1:0]    i_ram_rdata
);

    import mtd_pkg::*;

    t_state                         r_state, n_state;
    logic [ADDR_BITS-1:0]           r_clr, n_clr;
    logic [LINE_BITS-1:0]           r_wp, n_wp;
    logic signed [SAMPLE_BITS-1:0]  r_x, n_x;
    logic signed [WET_BITS-1:0]     r_wet, n_wet;
    logic [CNT_BITS-1:0]            r_k, n_k;
    logic [DLY_BITS-1:0]            r_delay, n_delay;
    logic signed [ACC_BITS-1:0]     r_acc, n_acc;
    logic [SAMPLE_BITS-1:0]         r_out, n_out;
    logic                           r_out_valid, n_out_valid;

    logic                           mul_en;
    logic [GAIN_BITS-1:0]           mul_gain;
    logic signed [WET_BITS-1:0]     mul_val;
    logic signed [PROD_BITS-1:0]    prod;

    logic [SUM_BITS-1:0]            delay_sum;
    logic [SUM_BITS-1:0]            spacing_ext;
    logic [DLY_BITS-1:0]            delay_step;
    logic [DLY_BITS-1:0]            delay_first;
    logic [DLY_BITS-1:0]            wp_ext;
    logic [DLY_BITS-1:0]            rd_full;
    logic [LINE_BITS-1:0]           wp_inc;
    logic [TAP_BITS-1:0]            tap_idx;
    logic signed [SAMPLE_BITS-1:0]  fb_sample;
    logic signed [ACC_BITS-1:0]     mix_sum;

    mtd_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (mul_en),
        .i_gain (mul_gain),
        .i_val  (mul_val),
        .o_prod (prod)
    );

    // Tap delays grow by one spacing per tap and stop at the line length.
    assign spacing_ext = SUM_BITS'(i_cfg.spacing);
    assign delay_sum   = SUM_BITS'(r_delay) + spacing_ext;
    assign delay_step  = (delay_sum > SUM_BITS'(LINE_DEPTH)) ? DLY_BITS'(LINE_DEPTH)
                                                             : delay_sum[DLY_BITS-1:0];
    assign delay_first = (spacing_ext > SUM_BITS'(LINE_DEPTH)) ? DLY_BITS'(LINE_DEPTH)
                                                               : spacing_ext[DLY_BITS-1:0];

    assign wp_ext  = DLY_BITS'(r_wp);
    assign rd_full = (wp_ext >= r_delay) ? (wp_ext - r_delay)
                                         : (wp_ext + DLY_BITS'(LINE_DEPTH) - r_delay);
    assign wp_inc  = (r_wp == LINE_BITS'(LINE_DEPTH - 1)) ? '0 : r_wp + LINE_BITS'(1);
    assign tap_idx = r_k[TAP_BITS-1:0];

    assign fb_sample = sat_sample(ACC_BITS'(r_x) + round_q15(ACC_BITS'(prod)));
    assign mix_sum   = r_acc + ACC_BITS'(prod);

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_wp        = r_wp;
        n_x         = r_x;
        n_wet       = r_wet;
        n_k         = r_k;
        n_delay     = r_delay;
        n_acc       = r_acc;
        n_out       = r_out;
        n_out_valid = r_out_valid;

        mul_en   = 1'b0;
        mul_gain = i_cfg.fb;
        mul_val  = r_wet;

        o_ram.we    = 1'b0;
        o_ram.waddr = {tap_idx, r_wp};
        o_ram.wdata = fb_sample;
        o_ram.raddr = {tap_idx, rd_full[LINE_BITS-1:0]};

        o_s_ready = (r_state == S_IDLE);

        if (r_out_valid && i_m_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_clr;
                o_ram.wdata = '0;
                n_clr       = r_clr + ADDR_BITS'(1);
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_s_valid) begin
                    n_x     = i_s_data;
                    n_wet   = '0;
                    n_k     = '0;
                    n_delay = delay_first;
                    n_state = (i_cfg.taps == '0) ? S_MIX_DRY : S_READ;
                end
            end
            S_READ: begin
                // Feedback product uses the wet sum of the earlier taps.
                mul_en = 1'b1;
                n_state = S_WRITE;
            end
            S_WRITE: begin
                // The line was read in S_READ, so a full-length delay
                // still returns the old sample at the write position.
                o_ram.we = 1'b1;
                n_wet    = r_wet + WET_BITS'(signed'(i_ram_rdata));
                n_k      = r_k + CNT_BITS'(1);
                n_delay  = delay_step;
                n_state  = (r_k + CNT_BITS'(1) == i_cfg.taps) ? S_MIX_DRY : S_READ;
            end
            S_MIX_DRY: begin
                mul_en   = 1'b1;
                mul_gain = i_cfg.dry;
                mul_val  = WET_BITS'(r_x);
                n_state  = S_MIX_WET;
            end
            S_MIX_WET: begin
                mul_en   = 1'b1;
                mul_gain = i_cfg.wet;
                mul_val  = r_wet;
                n_acc    = ACC_BITS'(prod);
                n_state  = S_MIX_WET == r_state ? S_DONE : r_state;
            end
            S_DONE: begin
                if (!r_out_valid || i_m_ready) begin
                    n_out       = sat_sample(round_q15(mix_sum));
                    n_out_valid = 1'b1;
                    n_wp        = wp_inc;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_wp        <= '0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_wp        <= n_wp;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x     <= n_x;
        r_wet   <= n_wet;
        r_delay <= n_delay;
        r_acc   <= n_acc;
        r_out   <= n_out;
    end

    assign o_m_valid = r_out_valid;
    assign o_m_data  = r_out;

endmodule

`default_nettype wire

@@ design/multi_tap_delay.sv @@
// ----------------------------------------------------------------------------
// multi_tap_delay
// Multi-tap delay effect on signed Q1.15 samples with feedback and dry/wet mix.
// ----------------------------------------------------------------------------
//  Channel   | Direction | Signals                           | Content
//  s_axis    | in        | tvalid, tready, tdata[15:0]       | in_sample
//  m_axis    | out       | tvalid, tready, tdata[15:0]       | out_sample
//  apb       | in/out    | psel, penable, pwrite, paddr,     | registers at 4*index
//            |           | pwdata, prdata, pready            |
//
//  From acceptance a sample passes through a read state and a write state
//  per tap (four taps after reset), which use the delay memory and the
//  single shared multiplier, then the dry mix, wet mix and done states into
//  the output register; a new sample is accepted only once the last one
//  has reached that register. After reset all 524288 entries of the delay
//  memory are zeroed one entry per cycle, during which s_axis_tready stays low.
//  A finished sample waits in the output register while the next one is
//  accepted; the block stalls in its last step only if that register is full.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_tap_delay (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  wire logic [15:0]                     s_axis_tdata,  // [15:0] in_sample
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output logic      [15:0]                     m_axis_tdata,  // [15:0] out_sample
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [mtd_pkg::PADDR_BITS-1:0]  paddr,
    input  wire logic [mtd_pkg::PDATA_BITS-1:0]  pwdata,
    output logic      [mtd_pkg::PDATA_BITS-1:0]  prdata,
    output logic                                 pready
);

    import mtd_pkg::*;

    t_cfg                   cfg;
    t_ram_req               ram_req;
    logic [SAMPLE_BITS-1:0] ram_rdata;

    mtd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mtd_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MEM_DEPTH)
    ) u_lines (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    mtd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_s_valid   (s_axis_tvalid),
        .o_s_ready   (s_axis_tready),
        .i_s_data    (s_axis_tdata),
        .o_m_valid   (m_axis_tvalid),
        .i_m_ready   (m_axis_tready),
        .o_m_data    (m_axis_tdata),
        .o_ram       (ram_req),
        .i_ram_rdata (ram_rdata)
    );

endmodule

`default_nettype wire

@@ design/mtd_chk.sv @@
// ----------------------------------------------------------------------------
// mtd_chk
// Port-level checks for the multi-tap delay, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mtd_chk (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            s_axis_tvalid,
    input wire logic                            s_axis_tready,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready,
    input wire logic [15:0]                     m_axis_tdata,
    input wire logic                            psel,
    input wire logic                            pready
);

    // A held result keeps its value until the transaction completes.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed while stalled");

    // The block works on one sample at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after a transaction");

    // A new result only appears after work that kept the input side closed.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result appeared without a sample in progress");

    // Reset empties the output and starts the memory clear.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid && !s_axis_tready)
        else $error("reset left the block active");

    a_pready_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel |-> pready)
        else $error("configuration port inserted wait state");

endmodule

bind multi_tap_delay mtd_chk u_chk (.*);

`default_nettype wire

@@ test/mtd_mix_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mtd_mix_checker
// Watches the sample streams and the register port of the multi-tap delay.
// It keeps its own copy of the delay lines and registers, predicts each
// output sample and compares it with the one that the block delivers.
// ----------------------------------------------------------------------------

module mtd_mix_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [15:0]                    i_s_tdata,   // [15:0] in_sample
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [15:0]                    i_m_tdata,   // [15:0] out_sample
    input  logic                           i_psel,
    input  logic                           i_penable,
    input  logic                           i_pwrite,
    input  logic                           i_pready,
    input  logic [mtd_pkg::PADDR_BITS-1:0] i_paddr,
    input  logic [mtd_pkg::PDATA_BITS-1:0] i_pwdata,
    output int                             o_pending,
    output int                             o_checked,
    output int                             o_fail_count
);

    import mtd_pkg::*;

    localparam longint Q15_HALF   = longint'(1) << (FRAC_BITS - 1);
    localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

    logic [TAP_COUNT_BITS-1:0] cfg_taps;
    logic [SPACING_BITS-1:0]   cfg_spacing;
    logic [LEVEL_BITS-1:0]     cfg_dry;
    logic [LEVEL_BITS-1:0]     cfg_wet;
    logic [GAIN_BITS-1:0]      cfg_fb;

    bit signed [SAMPLE_BITS-1:0] tap_mem [MAX_TAPS][LINE_DEPTH];
    int unsigned                 wr_pos;

    logic [15:0] pending_outs [$];
    int          fails;
    int          checked;

    initial begin
        o_pending    = 0;
        o_checked    = 0;
        o_fail_count = 0;
        fails        = 0;
        checked      = 0;
    end

    function automatic logic signed [SAMPLE_BITS-1:0] sat_q15(input longint v);
        if (v > SAMPLE_MAX) begin
            return SAMPLE_MAX[SAMPLE_BITS-1:0];
        end else if (v < SAMPLE_MIN) begin
            return SAMPLE_MIN[SAMPLE_BITS-1:0];
        end
        return v[SAMPLE_BITS-1:0];
    endfunction

    function automatic longint limit_gain(input logic [15:0] g);
        return (g > GAIN_ONE) ? longint'(GAIN_ONE) : longint'(g);
    endfunction

    // Runs one sample through all active taps, updates the delay lines and
    // returns the mixed output.
    function automatic logic [15:0] mix_sample(input logic signed [15:0] x);
        int unsigned taps;
        int unsigned step;
        int unsigned dly;
        int unsigned rd;
        int          k;
        longint      dry;
        longint      wetg;
        longint      fb;
        longint      wet;
        longint      delayed;
        taps = (cfg_taps > MAX_TAPS) ? MAX_TAPS : cfg_taps;
        step = (cfg_spacing == 0) ? 1 : cfg_spacing;
        dry  = limit_gain(cfg_dry);
        wetg = limit_gain(cfg_wet);
        fb   = limit_gain(cfg_fb);
        wet  = 0;
        for (k = 0; k < taps; k++) begin
            dly = (k + 1) * step;
            if (dly > LINE_DEPTH) begin
                dly = LINE_DEPTH;
            end
            // The line is read before this sample is written into it.
            rd = (wr_pos + LINE_DEPTH - dly) % LINE_DEPTH;
            delayed = tap_mem[k][rd];
            tap_mem[k][wr_pos] = sat_q15(longint'(x) + ((fb * wet + Q15_HALF) >>> FRAC_BITS));
            wet += delayed;
        end
        wr_pos = (wr_pos + 1) % LINE_DEPTH;
        return sat_q15((longint'(x) * dry + wet * wetg + Q15_HALF) >>> FRAC_BITS);
    endfunction

    always @(posedge i_clk) begin : watch
        logic [15:0]             want;
        logic [REG_IDX_BITS-1:0] idx;
        if (!i_rst_n) begin
            cfg_taps    = 4;
            cfg_spacing = 8192;
            cfg_dry     = GAIN_ONE;
            cfg_wet     = GAIN_ONE;
            cfg_fb      = '0;
            wr_pos      = 0;
            foreach (tap_mem[t, a]) begin
                tap_mem[t][a] = '0;
            end
            pending_outs.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                idx = i_paddr[PADDR_BITS-1:2];
                case (idx)
                    REG_TAP_COUNT:   cfg_taps    = i_pwdata[TAP_COUNT_BITS-1:0];
                    REG_TAP_SPACING: cfg_spacing = i_pwdata[SPACING_BITS-1:0];
                    REG_DRY_LEVEL:   cfg_dry     = i_pwdata[LEVEL_BITS-1:0];
                    REG_WET_LEVEL:   cfg_wet     = i_pwdata[LEVEL_BITS-1:0];
                    REG_FEEDBACK:    cfg_fb      = i_pwdata[GAIN_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                if (pending_outs.size() == 0) begin
                    if (fails < 10) begin
                        $display("unexpected output sample %0d", $signed(i_m_tdata));
                    end
                    fails++;
                end else begin
                    want = pending_outs.pop_front();
                    if (i_m_tdata !== want) begin
                        if (fails < 10) begin
                            $display("out_sample wrong at output %0d: expected %0d, got %0d",
                                     checked, $signed(want), $signed(i_m_tdata));
                        end
                        fails++;
                    end
                    checked++;
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                pending_outs.push_back(mix_sample(i_s_tdata));
            end
        end
        o_pending    <= pending_outs.size();
        o_checked    <= checked;
        o_fail_count <= fails;
    end

endmodule

@@ test/tb_multi_tap_delay.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_multi_tap_delay
// Drives samples and register writes into the multi-tap delay with random
// gaps and back-pressure; a checker beside the block predicts every output.
// ----------------------------------------------------------------------------

module tb_multi_tap_delay;
    import mtd_pkg::*;

    // After reset the delay memory is cleared entry by entry, all 524288 entries,
    // with no transaction; the idle limit allows for that clear before giving up.
    localparam int IDLE_LIMIT   = 1600000;
    localparam int HOLD_CYCLES  = 400;
    localparam int RANDOM_ITEMS = 1225;
    localparam int SETTLE_WAIT  = 24;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata  = '0;   // [15:0] in_sample
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [15:0]           m_axis_tdata;         // [15:0] out_sample
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [PADDR_BITS-1:0] paddr         = '0;
    logic [PDATA_BITS-1:0] pwdata        = '0;
    logic [PDATA_BITS-1:0] prdata;
    logic                  pready;

    int pending;
    int checked;
    int fail_count;
    int quiet_cycles = 0;
    int sent         = 0;
    int settings     = 1;

    logic [15:0] stim_q [$];

    multi_tap_delay DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    mtd_mix_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_pready     (pready),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .o_pending    (pending),
        .o_checked    (checked),
        .o_fail_count (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int idle_cycles(input bit burst);
        return burst ? 0 : $urandom_range(0, 11);
    endfunction

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2, 3, 4: return 16'($urandom_range(0, 4000) - 2000);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_gain();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return GAIN_ONE;
            2:       return 16'($urandom_range(32769, 65535));
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx, input logic [31:0] value);
        int          w;
        logic [31:0] junk;
        case (idx)
            REG_TAP_COUNT:   w = TAP_COUNT_BITS;
            REG_TAP_SPACING: w = SPACING_BITS;
            REG_DRY_LEVEL:   w = LEVEL_BITS;
            REG_WET_LEVEL:   w = LEVEL_BITS;
            REG_FEEDBACK:    w = GAIN_BITS;
            default:         w = 0;
        endcase
        // Bits above the field are ignored by the block; fill them half of the time.
        junk = $urandom_range(0, 1) ? ($urandom << w) : '0;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value | junk;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_mix(input logic [31:0] taps, input logic [31:0] spacing,
                           input logic [31:0] dry, input logic [31:0] wet,
                           input logic [31:0] fb);
        write_reg(REG_TAP_COUNT, taps);
        write_reg(REG_TAP_SPACING, spacing);
        write_reg(REG_DRY_LEVEL, dry);
        write_reg(REG_WET_LEVEL, wet);
        write_reg(REG_FEEDBACK, fb);
        settings++;
    endtask

    // Sends everything in stim_q, then drops tvalid.
    task automatic play_samples();
        int gap;
        bit burst;
        burst = $urandom_range(0, 1);
        while (stim_q.size() > 0) begin
            if ($urandom_range(0, 31) == 0) begin
                burst = !burst;
            end
            gap = idle_cycles(burst);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= stim_q.pop_front();
            do @(posedge i_clk); while (!s_axis_tready);
            sent++;
        end
        s_axis_tvalid <= 1'b0;
    endtask

    // Waits until every predicted output has come back and the block is idle.
    task automatic drain();
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Output side: random stalls with a couple of long hold-offs.
    initial begin : sink
        int gap;
        int taken;
        bit burst;
        taken = 0;
        burst = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 31) == 0) begin
                burst = !burst;
            end
            gap = idle_cycles(burst);
            // Holding off here lets the block fill up and stall its input.
            if (taken == 150 || taken == 700) begin
                gap = HOLD_CYCLES;
            end
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            taken++;
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable && pwrite && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("no transaction for %0d cycles", quiet_cycles);
            $display("multi_tap_delay: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int u;
        int n;
        int spacing;
        int taps;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Settings after reset; the first sample waits out the memory clear.
        stim_q = '{16'h0000, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 16'h5555, 16'hAAAA};
        play_samples();
        drain();

        // Every tap one sample apart with full feedback: tap writes and output saturate.
        set_mix(8, 1, GAIN_ONE, GAIN_ONE, GAIN_ONE);
        stim_q = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000,
                   16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h0001};
        play_samples();
        drain();

        // No taps: dry part only, with a dry gain above one.
        set_mix(0, 0, 16'hFFFF, 0, 0);
        for (u = REG_FEEDBACK + 1; u < (1 << REG_IDX_BITS); u++) begin
            write_reg(REG_IDX_BITS'(u), $urandom);
        end
        stim_q = '{16'h7FFF, 16'h8000, 16'hFFFF};
        play_samples();
        drain();

        // Tap count above the maximum and a zero spacing; the lines left
        // untouched by the previous setting come back into use.
        set_mix(15, 0, 0, 40000, 16'hFFFF);
        stim_q = '{16'h3039, 16'h8000, 16'h7FFF};
        play_samples();
        drain();

        // Largest spacing: the later taps run into the end of the line.
        set_mix(8, (1 << SPACING_BITS) - 1, GAIN_ONE, GAIN_ONE, 16384);
        stim_q = '{16'h7FFF, 16'h8000};
        play_samples();
        drain();

        n = 0;
        while (n < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       taps = 0;
                1:       taps = $urandom_range(MAX_TAPS + 1, 15);
                default: taps = $urandom_range(1, MAX_TAPS);
            endcase
            // Mostly short delays, so that the taps replay recent samples.
            case ($urandom_range(0, 9))
                7, 8:    spacing = $urandom_range(0, 300);
                9:       spacing = $urandom_range(0, (1 << SPACING_BITS) - 1);
                default: spacing = $urandom_range(1, 12);
            endcase
            set_mix(taps, spacing, pick_gain(), pick_gain(), pick_gain());
            u = $urandom_range(60, 140);
            repeat (u) stim_q.push_back(pick_sample());
            n += u;
            play_samples();
            drain();
        end

        repeat (SETTLE_WAIT) @(posedge i_clk);
        $display("%0d samples sent under %0d register settings, %0d outputs compared",
                 sent, settings, checked);
        $display("%0d mismatching or unexpected outputs", fail_count);
        if (fail_count == 0) begin
            $display("multi_tap_delay: match");
        end else begin
            $display("multi_tap_delay: mismatch");
        end
        $finish;
    end

endmodule
